FILE: rtl/pgc_pkg.sv
// Package with the shared types and constants of the pointer gesture classifier.
`default_nettype none

package pgc_pkg;

	// Configuration register indexes and their reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_CLICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;
	localparam logic [15:0] SINGLE_CLICK_RST = 16'd300;
	localparam logic [15:0] DOUBLE_CLICK_RST = 16'd200;

	// Pointer event kinds on the input.
	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_MOVE    = 3'd1,
		KIND_PRESS   = 3'd2,
		KIND_DRAG    = 3'd3,
		KIND_RELEASE = 3'd4
	} kind_t;

	// Gesture codes on the output.
	typedef enum logic [2:0] {
		G_CLICK_START = 3'd0,
		G_CLICK_END   = 3'd1,
		G_DBL_START   = 3'd2,
		G_DBL_END     = 3'd3,
		G_DRAG_START  = 3'd4,
		G_DRAGGING    = 3'd5,
		G_DRAG_END    = 3'd6,
		G_LONG_END    = 3'd7
	} gesture_t;

	// One result word as it waits in the output queue.
	typedef struct packed {
		logic [2:0]         gesture;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [2:0]         button;
		logic               last;
	} result_t;

endpackage : pgc_pkg

`default_nettype wire

FILE: rtl/pointer_gesture_classifier_unit.sv
// Pointer gesture classifier: input register, gesture logic and a two-word result queue.
// An input word goes through the input register, and its results through the result queue.
// Throughput: one input word per cycle when each causes at most one result; a press that
// forms a double click gives two result words, so it is taken only when the two-entry
// queue is empty or being emptied. The input stage stalls only when the queue lacks room.
// Reset (arst_n low, asynchronous) clears all gesture flags, times, held position and button
// and the queue, and loads the click thresholds with 300 ms and 200 ms.
`default_nettype none

module pointer_gesture_classifier_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [pgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                    cfg_data,
	// Input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [71:0]                    s_tdata,  // time_ms, x_pos, y_pos, button, zero fill
	input  wire logic [2:0]                     s_tuser,  // kind
	// Result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [39:0]                         m_tdata,  // out_x, out_y, out_button, zero fill
	output logic [2:0]                          m_tuser,  // gesture
	output logic                                m_tlast
);

	// Configuration registers.
	logic [15:0] single_ms_q;
	logic [15:0] double_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_ms_q <= pgc_pkg::SINGLE_CLICK_RST;
			double_ms_q <= pgc_pkg::DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pgc_pkg::REG_SINGLE_CLICK: single_ms_q <= cfg_data;
				pgc_pkg::REG_DOUBLE_CLICK: double_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic               v_s1;
	logic [2:0]         kind_s1;
	logic [31:0]        time_s1;
	logic signed [15:0] x_s1;
	logic signed [15:0] y_s1;
	logic [2:0]         btn_s1;
	logic               fire;

	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			time_s1 <= s_tdata[31:0];
			x_s1    <= s_tdata[47:32];
			y_s1    <= s_tdata[63:48];
			btn_s1  <= s_tdata[66:64];
		end
	end

	// Gesture state.
	logic               drag_q, dbl_q, await_q;
	logic [31:0]        press_time_q, release_time_q;
	logic signed [15:0] held_x_q, held_y_q;
	logic [2:0]         held_btn_q;

	logic               drag_d, dbl_d, await_d;
	logic [31:0]        press_time_d, release_time_d;
	logic signed [15:0] held_x_d, held_y_d;
	logic [2:0]         held_btn_d;
	logic [1:0]         nres;
	pgc_pkg::gesture_t  g0, g1;
	logic [31:0]        rel_dt, press_dt;

	assign rel_dt   = time_s1 - release_time_q;
	assign press_dt = time_s1 - press_time_q;

	// Classify the event and work out the next state.
	always_comb begin
		drag_d         = drag_q;
		dbl_d          = dbl_q;
		await_d        = await_q;
		press_time_d   = press_time_q;
		release_time_d = release_time_q;
		held_x_d       = held_x_q;
		held_y_d       = held_y_q;
		held_btn_d     = held_btn_q;
		nres           = 2'd0;
		g0             = pgc_pkg::G_CLICK_START;
		g1             = pgc_pkg::G_DBL_START;
		case (kind_s1)
			pgc_pkg::KIND_TICK: begin
				if (await_q && (rel_dt > {16'd0, double_ms_q})) begin
					await_d = 1'b0;
					g0      = pgc_pkg::G_CLICK_END;
					nres    = 2'd1;
				end
			end
			pgc_pkg::KIND_MOVE: begin
				held_x_d = x_s1;
				held_y_d = y_s1;
			end
			pgc_pkg::KIND_PRESS: begin
				held_x_d   = x_s1;
				held_y_d   = y_s1;
				held_btn_d = btn_s1;
				g0         = pgc_pkg::G_CLICK_START;
				nres       = 2'd1;
				// A second press inside the window after a real release forms a double click.
				if (await_q) begin
					if ((release_time_q != 32'd0) && (rel_dt < {16'd0, double_ms_q})) begin
						dbl_d = 1'b1;
						g1    = pgc_pkg::G_DBL_START;
						nres  = 2'd2;
					end
					await_d = 1'b0;
				end
				press_time_d = time_s1;
			end
			pgc_pkg::KIND_DRAG: begin
				held_x_d   = x_s1;
				held_y_d   = y_s1;
				held_btn_d = btn_s1;
				g0         = drag_q ? pgc_pkg::G_DRAGGING : pgc_pkg::G_DRAG_START;
				nres       = 2'd1;
				drag_d     = 1'b1;
			end
			pgc_pkg::KIND_RELEASE: begin
				held_x_d   = x_s1;
				held_y_d   = y_s1;
				held_btn_d = btn_s1;
				if (!drag_q) begin
					if (press_dt < {16'd0, single_ms_q}) begin
						if (!dbl_q) begin
							await_d = 1'b1;
						end else begin
							g0    = pgc_pkg::G_DBL_END;
							nres  = 2'd1;
							dbl_d = 1'b0;
						end
					end else begin
						g0   = pgc_pkg::G_LONG_END;
						nres = 2'd1;
					end
				end else begin
					drag_d = 1'b0;
					g0     = pgc_pkg::G_DRAG_END;
					nres   = 2'd1;
				end
				release_time_d = time_s1;
			end
			default: ;
		endcase
	end

	// Result queue of two words; the head is entry zero.
	pgc_pkg::result_t q_q [2];
	pgc_pkg::result_t q_d [2];
	pgc_pkg::result_t r0, r1;
	logic [1:0]       count_q, count_d, cnt_base;
	logic             pop;

	assign pop      = m_tvalid && m_tready;
	assign cnt_base = count_q - {1'b0, pop};
	assign fire     = v_s1 && (({1'b0, cnt_base} + {1'b0, nres}) <= 3'd2);

	assign r0 = '{gesture: g0, x: held_x_d, y: held_y_d, button: held_btn_d,
		last: (nres == 2'd1)};
	assign r1 = '{gesture: g1, x: held_x_d, y: held_y_d, button: held_btn_d, last: 1'b1};

	always_comb begin
		q_d[0]  = q_q[0];
		q_d[1]  = q_q[1];
		count_d = cnt_base;
		if (pop) begin
			q_d[0] = q_q[1];
		end
		if (fire) begin
			if (nres != 2'd0) begin
				q_d[cnt_base[0]] = r0;
			end
			if (nres == 2'd2) begin
				q_d[1] = r1;
			end
			count_d = cnt_base + nres;
		end
	end

	// State and queue control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q         <= 1'b0;
			dbl_q          <= 1'b0;
			await_q        <= 1'b0;
			press_time_q   <= '0;
			release_time_q <= '0;
			held_x_q       <= '0;
			held_y_q       <= '0;
			held_btn_q     <= '0;
			count_q        <= '0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				drag_q         <= drag_d;
				dbl_q          <= dbl_d;
				await_q        <= await_d;
				press_time_q   <= press_time_d;
				release_time_q <= release_time_d;
				held_x_q       <= held_x_d;
				held_y_q       <= held_y_d;
				held_btn_q     <= held_btn_d;
			end
		end
	end

	// Queue payload needs no reset.
	always_ff @(posedge clk) begin
		q_q[0] <= q_d[0];
		q_q[1] <= q_d[1];
	end

	// Master side outputs.
	assign m_tvalid = (count_q != 2'd0);
	assign m_tuser  = q_q[0].gesture;
	assign m_tlast  = q_q[0].last;
	assign m_tdata  = {5'd0, q_q[0].button, q_q[0].y, q_q[0].x};

	// The queue never holds more than two words.
	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("result queue count out of range");

	// A pending single click and an active double click exclude each other.
	assert property (@(posedge clk) disable iff (!arst_n) !(await_q && dbl_q))
		else $error("awaiting second click while double click is active");

	// A processed press always leaves a result word waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (kind_s1 == pgc_pkg::KIND_PRESS) |=> m_tvalid)
		else $error("press produced no result");

	// A stalled input word stays in place until processed.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !fire |=> v_s1 && $stable(kind_s1) && $stable(time_s1))
		else $error("stalled input word was lost");

endmodule : pointer_gesture_classifier_unit

`default_nettype wire
